@@ rtl/heading_pid_controller_defines.svh @@
// Assertion macros for the heading PID controller checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef HEADING_PID_CONTROLLER_DEFINES_SVH
`define HEADING_PID_CONTROLLER_DEFINES_SVH

// Check a property while out of reset.
`define HPID_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heading_pid_controller: property violated");

// Check a property at every edge, reset included.
`define HPID_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("heading_pid_controller: reset property violated");

`endif

@@ rtl/hpid_pkg.sv @@
// Shared widths, constants, register codes and controller types
// for the heading PID controller. No dependencies.
package hpid_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_WIDTH    = 24;
    localparam int ANGLE_WIDTH   = 26;
    localparam int ERR_WIDTH     = ANGLE_WIDTH + 1;
    localparam int SUM_WIDTH     = DATA_WIDTH + FRAC_BITS;
    localparam int TERM_WIDTH    = SUM_WIDTH + GAIN_WIDTH - FRAC_BITS;
    localparam int PID_WIDTH     = TERM_WIDTH + 2;
    localparam int ACC_WIDTH     = SUM_WIDTH + GAIN_WIDTH;
    localparam int A_HI_WIDTH    = SUM_WIDTH - GAIN_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic signed [ERR_WIDTH-1:0] HALF_TURN = ERR_WIDTH'(180 << FRAC_BITS);
    localparam logic signed [ERR_WIDTH-1:0] FULL_TURN = ERR_WIDTH'(360 << FRAC_BITS);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(SUM_WIDTH - 1);

    localparam logic [GAIN_WIDTH-1:0] KP_RESET = GAIN_WIDTH'(3 << FRAC_BITS);
    localparam logic [GAIN_WIDTH-1:0] KI_RESET = GAIN_WIDTH'((1 << FRAC_BITS) / 100);
    localparam logic [GAIN_WIDTH-1:0] KD_RESET = GAIN_WIDTH'(3 << FRAC_BITS);
    localparam logic signed [DATA_WIDTH-1:0] DRIVE_MIN_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] DRIVE_MAX_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROP_GAIN  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INTEG_GAIN = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DERIV_GAIN = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_MIN  = CFG_IDX_WIDTH'(3);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_MAX  = CFG_IDX_WIDTH'(4);

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D
    } hpid_msel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_SUM,
        ST_MUL_P,
        ST_WAIT_P,
        ST_MUL_D,
        ST_WAIT_D,
        ST_MUL_I,
        ST_WAIT_I,
        ST_CHECK,
        ST_DIV,
        ST_WAIT_DIV,
        ST_MUL_I2,
        ST_WAIT_I2,
        ST_ADD,
        ST_OUT
    } hpid_state_t;

    typedef struct packed {
        logic       load;
        logic       calc_err;
        logic       calc_sum;
        logic       mul_start;
        hpid_msel_t mul_sel;
        logic       div_start;
        logic       div_hi;
        logic       add_terms;
        logic       load_drive;
    } hpid_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic ki_zero;
        logic i_over;
        logic i_under;
        logic out_free;
    } hpid_status_t;

endpackage

@@ rtl/hpid_mul.sv @@
// Two-step gain multiplier: magnitude times gain, 24 bits of magnitude per step,
// then scale down by the fraction bits and restore the sign. Uses hpid_pkg.
module hpid_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [hpid_pkg::SUM_WIDTH-1:0]        mag,
    input  logic                                  neg,
    input  logic [hpid_pkg::GAIN_WIDTH-1:0]       gain,
    output logic                                  done,
    output logic signed [hpid_pkg::TERM_WIDTH-1:0] term
);
    import hpid_pkg::*;

    logic [SUM_WIDTH-1:0]               a_reg;
    logic [GAIN_WIDTH-1:0]              g_reg;
    logic                               neg_reg;
    logic [ACC_WIDTH-1:0]               acc_reg;
    logic                               step1_reg;
    logic                               step2_reg;
    logic                               step3_reg;
    logic [2*GAIN_WIDTH-1:0]            prod_lo;
    logic [A_HI_WIDTH+GAIN_WIDTH-1:0]   prod_hi;
    logic [TERM_WIDTH-1:0]              scaled;

    assign prod_lo = a_reg[GAIN_WIDTH-1:0] * g_reg;
    assign prod_hi = a_reg[SUM_WIDTH-1:GAIN_WIDTH] * g_reg;
    assign scaled  = acc_reg[ACC_WIDTH-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step1_reg <= 1'b0;
            step2_reg <= 1'b0;
            step3_reg <= 1'b0;
        end
        else
        begin
            step1_reg <= start;
            step2_reg <= step1_reg;
            step3_reg <= step2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= mag;
            g_reg   <= gain;
            neg_reg <= neg;
        end
        if (step1_reg)
        begin
            acc_reg <= ACC_WIDTH'(prod_lo);
        end
        else if (step2_reg)
        begin
            acc_reg <= acc_reg + {prod_hi, {GAIN_WIDTH{1'b0}}};
        end
    end

    assign done = step3_reg;
    assign term = neg_reg ? $signed(-scaled) : $signed(scaled);

endmodule

@@ rtl/hpid_div.sv @@
// Bit-serial restoring divider for the integral clamp: (|limit| << FRAC_BITS) / gain,
// one quotient bit per cycle, result signed and saturated to the accumulator width.
// Uses hpid_pkg.
module hpid_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [hpid_pkg::DATA_WIDTH-1:0] limit,
    input  logic [hpid_pkg::GAIN_WIDTH-1:0]       gain,
    output logic                                  done,
    output logic signed [hpid_pkg::SUM_WIDTH-1:0] quot
);
    import hpid_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg;
    logic [GAIN_WIDTH-1:0]    rem_reg;
    logic [SUM_WIDTH-1:0]     quo_reg;
    logic [GAIN_WIDTH-1:0]    g_reg;
    logic                     neg_reg;
    logic                     lim_neg;
    logic [DATA_WIDTH-1:0]    lim_mag;
    logic [GAIN_WIDTH:0]      trial;
    logic [GAIN_WIDTH:0]      trial_sub;
    logic                     fits;
    logic [GAIN_WIDTH-1:0]    rem_next;
    logic [SUM_WIDTH-1:0]     quo_next;

    assign lim_neg   = limit[DATA_WIDTH-1];
    assign lim_mag   = lim_neg ? -limit : limit;
    assign trial     = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign trial_sub = trial - {1'b0, g_reg};
    assign fits      = trial >= {1'b0, g_reg};
    assign rem_next  = fits ? trial_sub[GAIN_WIDTH-1:0] : trial[GAIN_WIDTH-1:0];
    assign quo_next  = {quo_reg[SUM_WIDTH-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {lim_mag, {FRAC_BITS{1'b0}}};
            g_reg   <= gain;
            neg_reg <= lim_neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quot = $signed(-quo_reg);
        end
        else if (quo_reg[SUM_WIDTH-1])
        begin
            quot = SUM_MAX;
        end
        else
        begin
            quot = $signed(quo_reg);
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/hpid_datapath.sv @@
// Datapath: configuration registers, error wrap, integral accumulator, PID terms,
// output saturation and result register. Uses hpid_pkg, hpid_mul and hpid_div.
module hpid_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [hpid_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [hpid_pkg::DATA_WIDTH-1:0]        cfg_data,
    input  logic signed [hpid_pkg::ANGLE_WIDTH-1:0] measured_angle,
    input  logic signed [hpid_pkg::ANGLE_WIDTH-1:0] target_angle,
    input  hpid_pkg::hpid_cmd_t                    cmd,
    output hpid_pkg::hpid_status_t                 status,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic signed [hpid_pkg::DATA_WIDTH-1:0] drive
);
    import hpid_pkg::*;

    logic [GAIN_WIDTH-1:0]          kp_reg;
    logic [GAIN_WIDTH-1:0]          ki_reg;
    logic [GAIN_WIDTH-1:0]          kd_reg;
    logic signed [DATA_WIDTH-1:0]   min_reg;
    logic signed [DATA_WIDTH-1:0]   max_reg;

    logic signed [ANGLE_WIDTH-1:0]  meas_reg;
    logic signed [ANGLE_WIDTH-1:0]  targ_reg;
    logic signed [DATA_WIDTH-1:0]   err_reg;
    logic signed [DATA_WIDTH:0]     diff_reg;
    logic signed [SUM_WIDTH-1:0]    sum_reg;
    logic signed [DATA_WIDTH-1:0]   last_reg;
    logic signed [TERM_WIDTH-1:0]   p_reg;
    logic signed [TERM_WIDTH-1:0]   i_reg;
    logic signed [TERM_WIDTH-1:0]   d_reg;
    logic signed [PID_WIDTH-1:0]    pid_reg;
    logic signed [DATA_WIDTH-1:0]   drive_reg;
    logic                           out_valid_reg;
    hpid_msel_t                     msel_reg;

    logic signed [ERR_WIDTH-1:0]    err_raw;
    logic signed [ERR_WIDTH-1:0]    err_wrap;
    logic signed [SUM_WIDTH:0]      sum_ext;
    logic signed [SUM_WIDTH-1:0]    sum_sat;
    logic signed [SUM_WIDTH-1:0]    mul_val;
    logic [SUM_WIDTH-1:0]           mul_mag;
    logic                           mul_neg;
    logic [GAIN_WIDTH-1:0]          mul_gain;
    logic                           mul_done;
    logic signed [TERM_WIDTH-1:0]   mul_term;
    logic                           div_done;
    logic signed [SUM_WIDTH-1:0]    div_quot;
    logic signed [DATA_WIDTH-1:0]   div_limit;
    logic signed [PID_WIDTH-1:0]    pid_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= KP_RESET;
            ki_reg  <= KI_RESET;
            kd_reg  <= KD_RESET;
            min_reg <= DRIVE_MIN_RESET;
            max_reg <= DRIVE_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  kp_reg  <= cfg_data[GAIN_WIDTH-1:0];
                CFG_INTEG_GAIN: ki_reg  <= cfg_data[GAIN_WIDTH-1:0];
                CFG_DERIV_GAIN: kd_reg  <= cfg_data[GAIN_WIDTH-1:0];
                CFG_DRIVE_MIN:  min_reg <= $signed(cfg_data);
                CFG_DRIVE_MAX:  max_reg <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    // wrap the error once into half a turn either way
    always_comb
    begin
        err_raw = ERR_WIDTH'(targ_reg) - ERR_WIDTH'(meas_reg);
        if (err_raw > HALF_TURN)
        begin
            err_wrap = err_raw - FULL_TURN;
        end
        else if (err_raw < -HALF_TURN)
        begin
            err_wrap = err_raw + FULL_TURN;
        end
        else
        begin
            err_wrap = err_raw;
        end
    end

    always_comb
    begin
        sum_ext = (SUM_WIDTH+1)'(sum_reg) + (SUM_WIDTH+1)'(err_reg);
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1])
        begin
            sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_ext[SUM_WIDTH-1:0];
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_P:
            begin
                mul_val  = SUM_WIDTH'(err_reg);
                mul_gain = kp_reg;
            end
            MSEL_D:
            begin
                mul_val  = SUM_WIDTH'(diff_reg);
                mul_gain = kd_reg;
            end
            default:
            begin
                mul_val  = sum_reg;
                mul_gain = ki_reg;
            end
        endcase
        mul_neg = mul_val[SUM_WIDTH-1];
        mul_mag = mul_neg ? -mul_val : mul_val;
    end

    assign div_limit = cmd.div_hi ? max_reg : min_reg;

    hpid_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .mag   (mul_mag),
        .neg   (mul_neg),
        .gain  (mul_gain),
        .done  (mul_done),
        .term  (mul_term)
    );

    hpid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .limit (div_limit),
        .gain  (ki_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            last_reg      <= '0;
            msel_reg      <= MSEL_P;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calc_sum)
            begin
                sum_reg  <= sum_sat;
                last_reg <= err_reg;
            end
            else if (div_done)
            begin
                sum_reg <= div_quot;
            end
            if (cmd.mul_start)
            begin
                msel_reg <= cmd.mul_sel;
            end
            if (cmd.load_drive)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // upper limit first, then lower: lower wins when the limits cross
    always_comb
    begin
        pid_lim = pid_reg;
        if (pid_reg > PID_WIDTH'(max_reg))
        begin
            pid_lim = PID_WIDTH'(max_reg);
        end
        if (pid_lim < PID_WIDTH'(min_reg))
        begin
            pid_lim = PID_WIDTH'(min_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= measured_angle;
            targ_reg <= target_angle;
        end
        if (cmd.calc_err)
        begin
            err_reg <= DATA_WIDTH'(err_wrap);
        end
        if (cmd.calc_sum)
        begin
            diff_reg <= (DATA_WIDTH+1)'(err_reg) - (DATA_WIDTH+1)'(last_reg);
            i_reg    <= '0;
        end
        else if (mul_done)
        begin
            case (msel_reg)
                MSEL_P:  p_reg <= mul_term;
                MSEL_D:  d_reg <= mul_term;
                default: i_reg <= mul_term;
            endcase
        end
        if (cmd.add_terms)
        begin
            pid_reg <= PID_WIDTH'(p_reg) + PID_WIDTH'(i_reg) + PID_WIDTH'(d_reg);
        end
        if (cmd.load_drive)
        begin
            drive_reg <= pid_lim[DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        status.mul_done = mul_done;
        status.div_done = div_done;
        status.ki_zero  = (ki_reg == '0);
        status.i_over   = (i_reg > TERM_WIDTH'(max_reg));
        status.i_under  = (i_reg < TERM_WIDTH'(min_reg));
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

@@ rtl/hpid_ctrl.sv @@
// Controller state machine: sequences error, accumulator, the three gain products,
// the integral clamp and the output load. Uses hpid_pkg.
module hpid_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output hpid_pkg::hpid_cmd_t    cmd,
    input  hpid_pkg::hpid_status_t status
);
    import hpid_pkg::*;

    hpid_state_t state_reg;
    hpid_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_WAIT_P;
            ST_WAIT_P:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:  state_next = ST_WAIT_D;
            ST_WAIT_D:
            begin
                if (status.mul_done)
                begin
                    state_next = status.ki_zero ? ST_ADD : ST_MUL_I;
                end
            end
            ST_MUL_I:  state_next = ST_WAIT_I;
            ST_WAIT_I:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (status.i_over || status.i_under) ? ST_DIV : ST_ADD;
            end
            ST_DIV:    state_next = ST_WAIT_DIV;
            ST_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MUL_I2;
                end
            end
            ST_MUL_I2: state_next = ST_WAIT_I2;
            ST_WAIT_I2:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ERR:    cmd.calc_err = 1'b1;
            ST_SUM:    cmd.calc_sum = 1'b1;
            ST_MUL_P:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_P;
            end
            ST_MUL_D:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_D;
            end
            ST_MUL_I, ST_MUL_I2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_I;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_hi    = status.i_over;
            end
            ST_ADD:    cmd.add_terms  = 1'b1;
            ST_OUT:    cmd.load_drive = status.out_free;
            default:   ;
        endcase
    end

endmodule

@@ rtl/heading_pid_controller.sv @@
// Heading PID controller, top level: controller plus datapath; uses hpid_pkg.
// The three gain products share one two-step multiplier and run one after another; with
// integ_gain zero the integral product is skipped, and when the integral clamps a
// bit-serial division and one more product follow. A new request is accepted only once
// the previous result has been loaded into the output register. Async reset clears the
// accumulator, last error and handshake state and restores the register defaults.
module heading_pid_controller (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hpid_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [hpid_pkg::DATA_WIDTH-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hpid_pkg::ANGLE_WIDTH-1:0] measured_angle,
    input  logic signed [hpid_pkg::ANGLE_WIDTH-1:0] target_angle,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [hpid_pkg::DATA_WIDTH-1:0] drive
);
    import hpid_pkg::*;

    hpid_cmd_t    cmd;
    hpid_status_t status;
    logic         cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    hpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    hpid_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .target_angle   (target_angle),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .drive          (drive)
    );

endmodule

@@ rtl/hpid_checker.sv @@
// Port-level checker for heading_pid_controller and the bind that attaches it.
// Uses hpid_pkg and heading_pid_controller_defines.svh.
`include "heading_pid_controller_defines.svh"

module hpid_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [hpid_pkg::DATA_WIDTH-1:0] drive
);

    `HPID_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(drive))
    `HPID_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready ##1 !in_ready)
    `HPID_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(!in_ready))
    `HPID_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready)

endmodule

bind heading_pid_controller hpid_checker u_checker (.*);

@@ test/tb_heading_pid_controller.sv @@
// Self-checking testbench for heading_pid_controller: heading pairs go in over valid/ready,
// an internal PID predictor forms each expected drive and results are compared in order.
// Depends on hpid_pkg and the heading_pid_controller RTL only.
`timescale 1ns / 1ps

module tb_heading_pid_controller;

    import hpid_pkg::*;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [DATA_WIDTH-1:0]  drive_t;

    localparam int DEG       = 1 << FRAC_BITS;
    localparam int ANGLE_LIM = 360 * DEG;
    localparam longint TERM_CAP = longint'(1) << 60;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = CFG_IDX_WIDTH'(7);
    localparam int SETTLE_CYCLES = 100;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [DATA_WIDTH-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    angle_t                   measured_angle;
    angle_t                   target_angle;
    logic                     out_valid;
    logic                     out_ready;
    drive_t                   drive;

    heading_pid_controller u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_angle (measured_angle),
        .target_angle   (target_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive)
    );

    logic [GAIN_WIDTH-1:0] kp_gain = KP_RESET;
    logic [GAIN_WIDTH-1:0] ki_gain = KI_RESET;
    logic [GAIN_WIDTH-1:0] kd_gain = KD_RESET;
    longint                lim_lo  = longint'(DRIVE_MIN_RESET);
    longint                lim_hi  = longint'(DRIVE_MAX_RESET);
    longint                err_acc = 0;
    longint                prev_err = 0;

    drive_t drive_expect[$];
    int     fail_count = 0;
    bit     tx_gaps = 1'b0;
    bit     rx_gaps = 1'b0;
    int     rx_hold = 0;
    longint heading_goal = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic angle_t clip_angle(longint v);
        if (v > ANGLE_LIM)
            v = ANGLE_LIM;
        if (v < -ANGLE_LIM)
            v = -ANGLE_LIM;
        return angle_t'(v);
    endfunction

    function automatic longint saturate(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // (v * g) >> FRAC_BITS toward zero, magnitude capped
    function automatic longint scale_by_gain(longint v, logic [GAIN_WIDTH-1:0] g);
        logic [63:0]  mag;
        logic [127:0] prod;
        mag = v < 0 ? 64'(-v) : 64'(v);
        prod = (128'(mag) * 128'(g)) >> FRAC_BITS;
        if (prod > 128'(TERM_CAP))
            prod = 128'(TERM_CAP);
        return v < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // (lim << FRAC_BITS) / g toward zero, held to the accumulator range
    function automatic longint clamp_quotient(longint lim, logic [GAIN_WIDTH-1:0] g);
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] cap;
        cap = 64'd1 << (SUM_WIDTH - 1);
        mag = lim < 0 ? 64'(-lim) : 64'(lim);
        quo = (mag << FRAC_BITS) / 64'(g);
        if (quo > cap)
            quo = cap;
        if (lim < 0)
            return -longint'(quo);
        return quo == cap ? longint'(cap - 1) : longint'(quo);
    endfunction

    function automatic void predict_drive(angle_t meas, angle_t targ);
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        err = longint'(targ) - longint'(meas);
        if (err > longint'(HALF_TURN))
            err -= longint'(FULL_TURN);
        else if (err < -longint'(HALF_TURN))
            err += longint'(FULL_TURN);
        err = saturate(err, DATA_WIDTH);
        p_term = scale_by_gain(err, kp_gain);
        err_acc = saturate(err_acc + err, SUM_WIDTH);
        i_term = 0;
        if (ki_gain != 0)
        begin
            i_term = scale_by_gain(err_acc, ki_gain);
            if (i_term > lim_hi)
            begin
                err_acc = clamp_quotient(lim_hi, ki_gain);
                i_term = scale_by_gain(err_acc, ki_gain);
            end
            else if (i_term < lim_lo)
            begin
                err_acc = clamp_quotient(lim_lo, ki_gain);
                i_term = scale_by_gain(err_acc, ki_gain);
            end
        end
        d_term = scale_by_gain(err - prev_err, kd_gain);
        prev_err = err;
        total = p_term + i_term + d_term;
        if (total > lim_hi)
            total = lim_hi;
        if (total < lim_lo)
            total = lim_lo;
        drive_expect.push_back(drive_t'(total));
    endfunction

    task automatic report_mismatch(input string what, input drive_t got, input drive_t want);
        fail_count++;
        $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PROP_GAIN:  kp_gain = val[GAIN_WIDTH-1:0];
            CFG_INTEG_GAIN: ki_gain = val[GAIN_WIDTH-1:0];
            CFG_DERIV_GAIN: kd_gain = val[GAIN_WIDTH-1:0];
            CFG_DRIVE_MIN:  lim_lo = longint'($signed(val));
            CFG_DRIVE_MAX:  lim_hi = longint'($signed(val));
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // gain write with random don't-care upper bits
    task automatic write_gain(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [GAIN_WIDTH-1:0] g);
        logic [DATA_WIDTH-1:0] val;
        val = $urandom;
        val[GAIN_WIDTH-1:0] = g;
        write_reg(idx, val);
    endtask

    task automatic send_heading(input angle_t meas, input angle_t targ);
        int gap;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        measured_angle <= meas;
        target_angle   <= targ;
        do
            @(posedge clk);
        while (!in_ready);
        predict_drive(meas, targ);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (drive_expect.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        drive_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_expect.size() == 0)
                report_mismatch("unexpected drive", drive, 'x);
            else
            begin
                want = drive_expect.pop_front();
                if (drive !== want)
                    report_mismatch("drive", drive, want);
            end
        end
    end

    task automatic test_wrap_and_extremes;
        send_heading(angle_t'(0), angle_t'(0));
        send_heading(angle_t'(-ANGLE_LIM), angle_t'(ANGLE_LIM));
        send_heading(angle_t'(ANGLE_LIM), angle_t'(-ANGLE_LIM));
        send_heading(angle_t'(0), angle_t'(HALF_TURN));
        send_heading(angle_t'(0), angle_t'(-HALF_TURN));
        send_heading(angle_t'(0), angle_t'(HALF_TURN + 1));
        send_heading(angle_t'(0), angle_t'(-HALF_TURN - 1));
        send_heading(angle_t'(HALF_TURN), angle_t'(-HALF_TURN));
        send_heading(angle_t'(ANGLE_LIM), angle_t'(ANGLE_LIM));
        send_heading(angle_t'(-1), angle_t'(1));
        drain_results();
    endtask

    task automatic test_gain_extremes;
        write_gain(CFG_PROP_GAIN, '1);
        write_gain(CFG_INTEG_GAIN, '1);
        write_gain(CFG_DERIV_GAIN, '1);
        send_heading(angle_t'(ANGLE_LIM), angle_t'(-ANGLE_LIM));
        send_heading(angle_t'(-ANGLE_LIM), angle_t'(ANGLE_LIM));
        drain_results();
        write_gain(CFG_PROP_GAIN, '0);
        write_gain(CFG_INTEG_GAIN, '0);
        write_gain(CFG_DERIV_GAIN, '0);
        send_heading(angle_t'(-ANGLE_LIM), angle_t'(0));
        drain_results();
        write_gain(CFG_PROP_GAIN, KP_RESET);
        write_gain(CFG_DERIV_GAIN, KD_RESET);
        send_heading(angle_t'(10 * DEG), angle_t'(-90 * DEG));
        send_heading(angle_t'(-45 * DEG), angle_t'(170 * DEG));
        drain_results();
    endtask

    task automatic test_integral_clamp;
        write_gain(CFG_PROP_GAIN, GAIN_WIDTH'(DEG));
        write_gain(CFG_INTEG_GAIN, GAIN_WIDTH'(DEG));
        write_gain(CFG_DERIV_GAIN, '0);
        write_reg(CFG_DRIVE_MIN, -10 * DEG);
        write_reg(CFG_DRIVE_MAX, 10 * DEG);
        send_heading(angle_t'(0), angle_t'(20 * DEG));
        send_heading(angle_t'(0), angle_t'(-40 * DEG));
        send_heading(angle_t'(0), angle_t'(-40 * DEG));
        drain_results();
        // crossed limits: the lower one wins
        write_reg(CFG_DRIVE_MIN, 5 * DEG);
        write_reg(CFG_DRIVE_MAX, -5 * DEG);
        send_heading(angle_t'(0), angle_t'(DEG));
        send_heading(angle_t'(0), angle_t'(-DEG));
        drain_results();
        write_reg(CFG_UNUSED, $urandom);
        send_heading(angle_t'(3 * DEG), angle_t'(0));
        drain_results();
    endtask

    task automatic test_backpressure;
        tx_gaps = 1'b0;
        rx_hold = 400;
        repeat (16)
            send_heading(angle_t'(rand_between(-ANGLE_LIM, ANGLE_LIM)),
                         angle_t'(rand_between(-ANGLE_LIM, ANGLE_LIM)));
        drain_results();
    endtask

    task automatic randomize_config;
        logic [GAIN_WIDTH-1:0] g;
        drive_t lo;
        drive_t hi;
        int w;
        for (int r = 0; r < 3; r++)
        begin
            case ($urandom_range(0, 5))
                0: g = '0;
                1: g = GAIN_WIDTH'(1);
                2: g = GAIN_WIDTH'(rand_between(1, 8 * DEG));
                3: g = '1;
                4: g = r == 1 ? KI_RESET : KP_RESET;
                default: g = GAIN_WIDTH'($urandom);
            endcase
            write_gain(r == 0 ? CFG_PROP_GAIN : (r == 1 ? CFG_INTEG_GAIN : CFG_DERIV_GAIN), g);
        end
        case ($urandom_range(0, 3))
            0:
            begin
                lo = DRIVE_MIN_RESET;
                hi = DRIVE_MAX_RESET;
            end
            1:
            begin
                w = rand_between(1, 2000) * DEG;
                lo = -w;
                hi = w;
            end
            2:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            default:
            begin
                lo = -rand_between(0, 500) * DEG;
                hi = rand_between(0, 500) * DEG;
            end
        endcase
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_WIDTH'(rand_between(5, 7)), $urandom);
    endtask

    task automatic next_heading_pair(output angle_t meas, output angle_t targ);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            heading_goal = clip_angle(heading_goal + rand_between(-2 * DEG, 2 * DEG));
            targ = angle_t'(heading_goal);
            if (mode == 5)
                meas = clip_angle(heading_goal + (heading_goal > 0 ? -360 : 360) * DEG
                                  + rand_between(-5 * DEG, 5 * DEG));
            else
                meas = clip_angle(heading_goal + rand_between(-5 * DEG, 5 * DEG));
        end
        else if (mode < 8)
        begin
            meas = angle_t'(rand_between(-ANGLE_LIM, ANGLE_LIM));
            targ = angle_t'(rand_between(-ANGLE_LIM, ANGLE_LIM));
        end
        else if (mode == 8)
        begin
            meas = angle_t'(rand_between(-180 * DEG, 180 * DEG));
            case ($urandom_range(0, 3))
                0: targ = clip_angle(longint'(meas) + HALF_TURN);
                1: targ = clip_angle(longint'(meas) - HALF_TURN);
                2: targ = clip_angle(longint'(meas) + HALF_TURN + 1);
                default: targ = clip_angle(longint'(meas) - HALF_TURN - 1);
            endcase
        end
        else
        begin
            meas = angle_t'(rand_between(-1, 1) * ANGLE_LIM);
            targ = angle_t'(rand_between(-1, 1) * ANGLE_LIM);
        end
    endtask

    task automatic test_random_tracking;
        angle_t meas;
        angle_t targ;
        for (int phase = 0; phase < 16; phase++)
        begin
            randomize_config();
            tx_gaps = phase < 14 && $urandom_range(0, 3) != 0;
            rx_gaps = phase < 14 && $urandom_range(0, 3) != 0;
            repeat (100)
            begin
                next_heading_pair(meas, targ);
                send_heading(meas, targ);
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        measured_angle = '0;
        target_angle   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wrap_and_extremes();
        test_gain_extremes();
        test_integral_clamp();
        test_backpressure();
        test_random_tracking();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
